// ===== sv/bfe_pkg.sv =====
// Package for the 3x3 edge-averaging box filter: item types, register
// indexes, size constants and the state type. Depends on nothing.
`default_nettype none

package bfe_pkg;

  localparam int PIX_W             = 8;
  localparam int FRAME_W_BITS      = 9;
  localparam int FRAME_H_BITS      = 13;
  localparam int OUT_ROW_W         = 12;
  localparam int SUM_W             = 12;
  localparam int DEFAULT_MAX_WIDTH = 256;
  localparam int HEIGHT_LIMIT      = 4096;

  // Reciprocals scaled by 2**RECIP_SHIFT, rounded up; exact for the sums seen here.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP3 = 15'd21846;
  localparam logic [RECIP_W-1:0] RECIP9 = 15'd7282;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [FRAME_W_BITS-1:0] RESET_WIDTH  = 9'd256;
  localparam logic [FRAME_H_BITS-1:0] RESET_HEIGHT = 13'd256;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             last_of_frame;
  } out_item_t;

  // Window sum with the number of in-frame columns and rows (1 to 3 each).
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [1:0]       col_cnt;
    logic [1:0]       row_cnt;
  } avg_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } bfe_state_t;

endpackage

`default_nettype wire

// ===== sv/bfe_line_store.sv =====
// Dual line store: one synchronous RAM holding the upper and middle rows
// side by side, with a registered read port. Depends on bfe_pkg.
`default_nettype none

module bfe_line_store
  import bfe_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEFAULT_MAX_WIDTH)
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [2*PIX_W-1:0] rd_data,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [2*PIX_W-1:0] wr_data
);

  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a waiting step still sees it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bfe_average.sv =====
// Divides a window sum by its pixel count (1, 2, 3, 4, 6 or 9) through a
// reciprocal multiply and shifts. Depends on bfe_pkg.
`default_nettype none

module bfe_average
  import bfe_pkg::*;
(
  input  wire avg_req_t         req,
  output logic      [PIX_W-1:0] quot
);

  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int QM_W   = PIX_W + 1;

  logic               both3;
  logic               any3;
  logic [1:0]         other;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [QM_W-1:0]    q_mul;
  logic [SUM_W-1:0]   q_shift;

  always_comb begin
    both3 = (req.col_cnt == 2'd3) && (req.row_cnt == 2'd3);
    any3  = (req.col_cnt == 2'd3) || (req.row_cnt == 2'd3);
    other = (req.col_cnt == 2'd3) ? req.row_cnt : req.col_cnt;
    recip = both3 ? RECIP9 : RECIP3;
    prod  = PROD_W'(req.sum) * PROD_W'(recip);
    q_mul = prod[RECIP_SHIFT +: QM_W];
    // Without a factor of three the count is a power of two.
    q_shift = req.sum >> ((req.col_cnt - 2'd1) + (req.row_cnt - 2'd1));
    if (both3) begin
      quot = q_mul[PIX_W-1:0];
    end else if (any3) begin
      quot = (other == 2'd2) ? q_mul[QM_W-1:1] : q_mul[PIX_W-1:0];
    end else begin
      quot = q_shift[PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/box_filter_3x3_edge_average.sv =====
// 3x3 mean filter with edge-aware averaging over a raster pixel stream.
// Uses bfe_pkg, bfe_line_store and bfe_average.
//
// Input channel (in_valid, in_stall, in_data): one item per raster pixel
// (command 0), then frame_width+1 flush items (command 1) after the last
// pixel drain the remaining results. A flush before the frame's pixels are
// all in is taken and dropped. Output channel (out_valid, out_stall,
// out_data): one result per frame position in raster order; the frame's
// final result carries last_of_frame, after which a new frame begins.
// A new item waits until the last one's step is done, since the line store
// entry is read when an item is taken and written back in its step through
// the single RAM. After the step a result passes through the averaging
// register and then the output register.
// Results trail the input by frame_width+1 items.
// When the receiver stalls, the output register holds its result, the
// averaging register fills, and then the step cycle waits, which in turn
// keeps in_stall high. Reset (rst_n low, synchronous) empties the pipeline,
// sets both frame registers to 256 and restarts the frame; a write to
// either frame register also restarts the frame. Line store contents are
// not cleared: entries are always written before they feed an in-frame tap.
`default_nettype none

module box_filter_3x3_edge_average
  import bfe_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = COL_W + 1;

  logic [FRAME_W_BITS-1:0] frame_width_r;
  logic [FRAME_H_BITS-1:0] frame_height_r;
  logic [WCNT_W-1:0]       eff_w;
  logic [FRAME_H_BITS-1:0] eff_h;
  logic                    cfg_restart;

  bfe_state_t state_r, state_nxt;

  logic [FRAME_H_BITS-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]        in_col_r, in_col_nxt;
  logic [OUT_ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [COL_W-1:0]        out_col_r, out_col_nxt;

  logic [2:0][2:0][PIX_W-1:0] window_r, window_nxt;
  logic [PIX_W-1:0]           v_r;

  logic               ls_rd_en;
  logic               ls_wr_en;
  logic [2*PIX_W-1:0] ls_rd_data;

  logic in_accept;
  logic in_frame;
  logic ignore_item;
  logic step_en;
  logic emit;
  logic last;
  logic [2:0] col_use;
  logic [2:0] row_use;
  avg_req_t   req_nxt;

  avg_req_t         div_r;
  logic             div_last_r;
  logic             div_valid_r;
  logic             div_move;
  logic             div_free;
  logic [PIX_W-1:0] quot;

  out_item_t out_data_r;
  logic      out_valid_r;

  // Effective frame size after clamping the registers.
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = WCNT_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      eff_w = WCNT_W'(MAX_WIDTH);
    end else begin
      eff_w = WCNT_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = FRAME_H_BITS'(1);
    end else if (32'(frame_height_r) > HEIGHT_LIMIT) begin
      eff_h = FRAME_H_BITS'(HEIGHT_LIMIT);
    end else begin
      eff_h = frame_height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_WIDTH;
      frame_height_r <= RESET_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FRAME_W_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only a write to an existing frame register restarts the frame.
  assign cfg_restart = cfg_wr_en &&
                       (cfg_index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});

  assign in_accept   = in_valid && !in_stall;
  assign in_frame    = in_row_r < eff_h;
  assign ignore_item = in_frame && (in_data.command == CMD_FLUSH);
  assign div_move    = div_valid_r && (!out_valid_r || !out_stall);
  assign div_free    = !div_valid_r || div_move;

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    ls_rd_en  = 1'b0;
    step_en   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !ignore_item) begin
          ls_rd_en  = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (div_free) begin
          step_en   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Flush slots past the last row carry zero into the window.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      v_r <= in_frame ? in_data.pixel : '0;
    end
  end

  bfe_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (ls_rd_en),
    .rd_addr (in_col_r),
    .rd_data (ls_rd_data),
    .wr_en   (ls_wr_en),
    .wr_addr (in_col_r),
    .wr_data ({ls_rd_data[PIX_W-1:0], v_r})
  );

  assign ls_wr_en = step_en;

  // One step: shift the window, add up the in-frame taps, advance positions.
  always_comb begin
    window_nxt[0] = window_r[1];
    window_nxt[1] = window_r[2];
    window_nxt[2] = {v_r, ls_rd_data[PIX_W-1:0], ls_rd_data[2*PIX_W-1:PIX_W]};

    emit = (in_row_r >= FRAME_H_BITS'(2)) ||
           ((in_row_r == FRAME_H_BITS'(1)) && (in_col_r != '0));

    col_use[0] = (out_col_r != '0);
    col_use[1] = 1'b1;
    col_use[2] = ({1'b0, out_col_r} + WCNT_W'(1)) < eff_w;
    row_use[0] = (out_row_r != '0);
    row_use[1] = 1'b1;
    row_use[2] = ({1'b0, out_row_r} + FRAME_H_BITS'(1)) < eff_h;

    req_nxt.sum = '0;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        if (col_use[dc] && row_use[dr]) begin
          req_nxt.sum = req_nxt.sum + SUM_W'(window_nxt[dc][dr]);
        end
      end
    end
    req_nxt.col_cnt = 2'd1 + {1'b0, col_use[0]} + {1'b0, col_use[2]};
    req_nxt.row_cnt = 2'd1 + {1'b0, row_use[0]} + {1'b0, row_use[2]};
    last = !col_use[2] && !row_use[2];

    if (({1'b0, in_col_r} + WCNT_W'(1)) >= eff_w) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + FRAME_H_BITS'(1);
    end else begin
      in_col_nxt = in_col_r + COL_W'(1);
      in_row_nxt = in_row_r;
    end

    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      if (!col_use[2]) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + OUT_ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      window_r  <= '0;
    end else if (cfg_restart) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (step_en) begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      window_r  <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r <= 1'b0;
    end else if (step_en && emit) begin
      div_valid_r <= 1'b1;
    end else if (div_move) begin
      div_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      div_r      <= req_nxt;
      div_last_r <= last;
    end
  end

  bfe_average u_average (
    .req  (div_r),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_move) begin
      out_data_r.smoothed      <= quot;
      out_data_r.last_of_frame <= div_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The line store must never be read and written in one cycle.
  a_ls_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ls_rd_en && ls_wr_en))
    else $error("line store read and write in the same cycle");

  // Input column always lies inside the effective frame width.
  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, in_col_r} < eff_w))
    else $error("input column outside frame");

  // Output position always lies inside the effective frame.
  a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, out_col_r} < eff_w) && ({1'b0, out_row_r} < eff_h)))
    else $error("output position outside frame");

endmodule

`default_nettype wire
